[hw/rtl/fps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int TIME_W    = 32;
  localparam int TAG_W     = 16;
  localparam int MIN_LAT_W = 24;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 3;

  // Stream word widths (fields packed, padded to whole bytes)
  localparam int IN_RAW_W    = TAG_W + 3 * TIME_W;
  localparam int IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = 1 + TAG_W + 5 * TIME_W + CNT_W;
  localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED     = 3'd0,
    ST_STALE_DROP = 3'd1,
    ST_FULL_DROP  = 3'd2,
    ST_NEW_FRAME  = 3'd3,
    ST_NO_NEW     = 3'd4,
    ST_BACKWARD   = 3'd5,
    ST_FLUSHED    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH_WR,
    S_TICK_CMP,
    S_TICK_FIN,
    S_DONE
  } state_t;

  // One queued frame
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] source;
    logic [TIME_W-1:0] ready;
    logic [TIME_W-1:0] eligible;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    calc_elig;
    logic    push_wr;
    logic    tick_arm;
    logic    rd_head;
    logic    pop;
    logic    set_disp;
    logic    flush;
    logic    set_status;
    status_t status;
    logic    out_load;
  } fps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              stale;
    logic              full;
    logic              backward;
    logic              empty;
    logic              elig_ok;
    logic              one_left;
    logic              popped;
    logic              out_free;
  } fps_sts_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fps_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module fps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hw/rtl/fps_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fps_ctrl import fps_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire fps_sts_t sts,
  output fps_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = ST_NO_NEW;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.mode)
          MODE_PUSH: begin
            if (sts.stale) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_STALE_DROP;
              state_nxt      = S_DONE;
            end else if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL_DROP;
              state_nxt      = S_DONE;
            end else begin
              cmd.calc_elig = 1'b1;
              state_nxt     = S_PUSH_WR;
            end
          end
          MODE_TICK: begin
            if (sts.backward) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BACKWARD;
              state_nxt      = S_DONE;
            end else begin
              cmd.tick_arm = 1'b1;
              if (sts.empty) begin
                state_nxt = S_TICK_FIN;
              end else begin
                cmd.rd_head = 1'b1;
                state_nxt   = S_TICK_CMP;
              end
            end
          end
          MODE_FLUSH: begin
            cmd.flush      = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_FLUSHED;
            state_nxt      = S_DONE;
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_NO_NEW;
            state_nxt      = S_DONE;
          end
        endcase
      end
      S_PUSH_WR: begin
        cmd.push_wr    = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ST_PUSHED;
        state_nxt      = S_DONE;
      end
      S_TICK_CMP: begin
        // Pop the head if due and fetch the next one in the same cycle
        if (sts.elig_ok) begin
          cmd.pop = 1'b1;
          if (sts.one_left) begin
            state_nxt = S_TICK_FIN;
          end else begin
            cmd.rd_head = 1'b1;
          end
        end else begin
          state_nxt = S_TICK_FIN;
        end
      end
      S_TICK_FIN: begin
        cmd.set_disp   = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = sts.popped ? ST_NEW_FRAME : ST_NO_NEW;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A head compare always follows a read of the head entry
  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TICK_CMP |-> $past(cmd.rd_head))
    else $error("head compare without a preceding read");

  // An accepted word always goes on to be decoded
  a_accept_then_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> state_r == S_DECODE)
    else $error("accepted word not decoded");

endmodule

`default_nettype wire

[hw/rtl/fps_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module fps_dp import fps_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [MIN_LAT_W-1:0] cfg_data,
  input  wire logic [MODE_W-1:0]    in_mode,
  input  wire logic [TAG_W-1:0]     in_tag,
  input  wire logic [TIME_W-1:0]    in_source,
  input  wire logic [TIME_W-1:0]    in_ready_time,
  input  wire logic [TIME_W-1:0]    in_display,
  input  wire fps_cmd_t             cmd,
  output fps_sts_t                  sts,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [STATUS_W-1:0]       out_status,
  output logic                      out_has_frame,
  output logic [TAG_W-1:0]          out_tag,
  output logic [TIME_W-1:0]         out_source,
  output logic [TIME_W-1:0]         out_ready_time,
  output logic [TIME_W-1:0]         out_eligible,
  output logic [TIME_W-1:0]         out_display,
  output logic [TIME_W-1:0]         out_latency,
  output logic [CNT_W-1:0]          out_count
);

  // Configuration and captured word
  logic [MIN_LAT_W-1:0] min_lat_r;
  logic [MODE_W-1:0]    mode_r;
  logic [TAG_W-1:0]     tag_r;
  logic [TIME_W-1:0]    src_r;
  logic [TIME_W-1:0]    rdy_r;
  logic [TIME_W-1:0]    disp_r;
  logic [TIME_W-1:0]    elig_r;

  // Queue control
  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] tail_r;
  logic [CNT_W-1:0] count_r;

  // Presented frame and tick history
  logic              last_valid_r;
  logic [TAG_W-1:0]  last_tag_r;
  logic [TIME_W-1:0] last_source_r;
  logic [TIME_W-1:0] last_ready_r;
  logic [TIME_W-1:0] last_elig_r;
  logic [TIME_W-1:0] last_disp_r;
  logic              updated_once_r;
  logic [TIME_W-1:0] prev_tick_r;
  logic              popped_r;
  status_t           status_r;

  // Output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_has_frame_r;
  logic [TAG_W-1:0]    out_tag_r;
  logic [TIME_W-1:0]   out_source_r;
  logic [TIME_W-1:0]   out_ready_r;
  logic [TIME_W-1:0]   out_elig_r;
  logic [TIME_W-1:0]   out_disp_r;
  logic [TIME_W-1:0]   out_latency_r;
  logic [CNT_W-1:0]    out_count_r;

  // Queue storage
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic [ENTRY_W-1:0] rd_raw;
  logic [PTR_W-1:0]  rd_addr;

  // Eligible time: saturated source plus latency, then at least ready time
  logic [TIME_W:0]   elig_sum;
  logic [TIME_W-1:0] elig_sat;
  logic [TIME_W-1:0] elig_calc;

  assign elig_sum  = {1'b0, src_r} + {{(TIME_W + 1 - MIN_LAT_W){1'b0}}, min_lat_r};
  assign elig_sat  = elig_sum[TIME_W] ? '1 : elig_sum[TIME_W-1:0];
  assign elig_calc = (rdy_r > elig_sat) ? rdy_r : elig_sat;

  assign wr_entry.tag      = tag_r;
  assign wr_entry.source   = src_r;
  assign wr_entry.ready    = rdy_r;
  assign wr_entry.eligible = elig_r;
  assign rd_entry          = entry_t'(rd_raw);
  assign rd_addr           = cmd.pop ? ptr_next(head_r) : head_r;

  fps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (cmd.push_wr),
    .wr_addr (tail_r),
    .wr_data (wr_entry),
    .rd_en   (cmd.rd_head),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // Status to the controller
  assign sts.mode     = mode_r;
  assign sts.stale    = last_valid_r && (src_r <= last_source_r);
  assign sts.full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign sts.backward = updated_once_r && (disp_r < prev_tick_r);
  assign sts.empty    = (count_r == '0);
  assign sts.elig_ok  = (rd_entry.eligible <= disp_r);
  assign sts.one_left = (count_r == CNT_W'(1));
  assign sts.popped   = popped_r;
  assign sts.out_free = !out_valid_r || out_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_lat_r <= '0;
    end else if (cfg_we) begin
      min_lat_r <= cfg_data;
    end
  end

  // Capture the accepted word and the computed eligible time
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      tag_r  <= in_tag;
      src_r  <= in_source;
      rdy_r  <= in_ready_time;
      disp_r <= in_display;
    end
    if (cmd.calc_elig) begin
      elig_r <= elig_calc;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  // Queue pointers, presented frame and tick history
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.flush) begin
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      last_valid_r   <= 1'b0;
      last_tag_r     <= '0;
      last_source_r  <= '0;
      last_ready_r   <= '0;
      last_elig_r    <= '0;
      last_disp_r    <= '0;
      updated_once_r <= 1'b0;
      prev_tick_r    <= '0;
      popped_r       <= 1'b0;
    end else begin
      if (cmd.push_wr) begin
        tail_r  <= ptr_next(tail_r);
        count_r <= count_r + 1'b1;
      end
      if (cmd.tick_arm) begin
        updated_once_r <= 1'b1;
        prev_tick_r    <= disp_r;
        popped_r       <= 1'b0;
      end
      if (cmd.pop) begin
        last_valid_r  <= 1'b1;
        last_tag_r    <= rd_entry.tag;
        last_source_r <= rd_entry.source;
        last_ready_r  <= rd_entry.ready;
        last_elig_r   <= rd_entry.eligible;
        popped_r      <= 1'b1;
        head_r        <= ptr_next(head_r);
        count_r       <= count_r - 1'b1;
      end
      if (cmd.set_disp && last_valid_r) begin
        last_disp_r <= disp_r;
      end
    end
  end

  // Output register: load the finished word, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r    <= status_r;
      out_has_frame_r <= last_valid_r;
      out_tag_r       <= last_tag_r;
      out_source_r    <= last_source_r;
      out_ready_r     <= last_ready_r;
      out_elig_r      <= last_elig_r;
      out_disp_r      <= last_disp_r;
      out_latency_r   <= last_disp_r - last_source_r;
      out_count_r     <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_has_frame  = out_has_frame_r;
  assign out_tag        = out_tag_r;
  assign out_source     = out_source_r;
  assign out_ready_time = out_ready_r;
  assign out_eligible   = out_elig_r;
  assign out_display    = out_disp_r;
  assign out_latency    = out_latency_r;
  assign out_count      = out_count_r;

  // Fill level never passes the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // Never pop an empty queue or push a full one
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> count_r != CNT_W'(QUEUE_DEPTH))
    else $error("push into full queue");

  // A waiting result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

[hw/rtl/frame_presentation_scheduler_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Word                                   Handshake
// in_      slave      tuser: mode; tdata: tag, source,       in_tvalid / in_tready
//                     ready, display time
// out_     master     tuser: status; tdata: has_frame, tag,  out_tvalid / out_tready
//                     source, ready, eligible, display,
//                     latency, queued count
// cfg_     slave      cfg_data: min_latency_us               cfg_valid / cfg_ready
//
// One word is processed at a time. A display tick pops due frames from the
// queue head, one queue entry per cycle, through the registered read port of
// the queue memory.
// Reset is synchronous and clears pointers, count, presented frame and
// tick history; queue entries are left unwritten.
// A result waits in the output register while out_tready is low; the next
// word is accepted meanwhile, and its result waits behind that one.

module frame_presentation_scheduler_top import fps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input words
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // frame_tag, source_time_us,
                                                // ready_time_us, display_time_us
  input  wire logic [MODE_W-1:0]     in_tuser,  // mode
  // Result words
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata, // has_frame, shown_tag,
                                                // shown_source_us, shown_ready_us,
                                                // shown_eligible_us,
                                                // shown_display_us, latency_us,
                                                // queued_count, zero pad
  output logic [STATUS_W-1:0]        out_tuser, // status
  // Configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [MIN_LAT_W-1:0]  cfg_data   // min_latency_us
);

  fps_cmd_t cmd;
  fps_sts_t sts;

  logic                in_valid_ready;
  logic                out_has_frame;
  logic [TAG_W-1:0]    out_tag;
  logic [TIME_W-1:0]   out_source;
  logic [TIME_W-1:0]   out_ready_time;
  logic [TIME_W-1:0]   out_eligible;
  logic [TIME_W-1:0]   out_display;
  logic [TIME_W-1:0]   out_latency;
  logic [CNT_W-1:0]    out_count;

  assign cfg_ready = 1'b1;

  fps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_valid_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_tready = in_valid_ready;

  fps_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .in_mode        (in_tuser),
    .in_tag         (in_tdata[TAG_W-1:0]),
    .in_source      (in_tdata[TAG_W +: TIME_W]),
    .in_ready_time  (in_tdata[TAG_W + TIME_W +: TIME_W]),
    .in_display     (in_tdata[TAG_W + 2 * TIME_W +: TIME_W]),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_status     (out_tuser),
    .out_has_frame  (out_has_frame),
    .out_tag        (out_tag),
    .out_source     (out_source),
    .out_ready_time (out_ready_time),
    .out_eligible   (out_eligible),
    .out_display    (out_display),
    .out_latency    (out_latency),
    .out_count      (out_count)
  );

  // Pack the result word, lowest field first
  assign out_tdata = {{(OUT_DATA_W - OUT_RAW_W){1'b0}},
                      out_count, out_latency, out_display, out_eligible,
                      out_ready_time, out_source, out_tag, out_has_frame};

endmodule

`default_nettype wire

[sim/tb_frame_presentation_scheduler_top.sv]
`timescale 1ns / 1ps

module tb_frame_presentation_scheduler_top;
  import fps_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned LAT_MAX = 10000000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 160;

  // Offsets of the result word fields, lowest bit first
  localparam int O_TAG  = 1;
  localparam int O_SRC  = O_TAG + TAG_W;
  localparam int O_RDY  = O_SRC + TIME_W;
  localparam int O_ELIG = O_RDY + TIME_W;
  localparam int O_DISP = O_ELIG + TIME_W;
  localparam int O_LAT  = O_DISP + TIME_W;
  localparam int O_CNT  = O_LAT + TIME_W;

  typedef struct packed {
    status_t             status;
    logic                has_frame;
    logic [TAG_W-1:0]    tag;
    logic [TIME_W-1:0]   source;
    logic [TIME_W-1:0]   ready;
    logic [TIME_W-1:0]   eligible;
    logic [TIME_W-1:0]   display;
    logic [TIME_W-1:0]   latency;
    logic [CNT_W-1:0]    queued;
  } pacing_report_t;

  // Pacing queue predictor plus the store of reports it still owes
  class frame_pacing_scoreboard;
    logic [MIN_LAT_W-1:0] min_lat;
    logic [TAG_W-1:0]     q_tag[QUEUE_DEPTH];
    logic [TIME_W-1:0]    q_src[QUEUE_DEPTH];
    logic [TIME_W-1:0]    q_rdy[QUEUE_DEPTH];
    logic [TIME_W-1:0]    q_elig[QUEUE_DEPTH];
    int                   head, tail, entries;
    bit                   shown_valid;
    logic [TAG_W-1:0]     shown_tag;
    logic [TIME_W-1:0]    shown_src, shown_rdy, shown_elig, shown_disp;
    bit                   ticked;
    logic [TIME_W-1:0]    last_tick;
    pacing_report_t       expected_reports[$];
    int                   errors;
    int                   checked;

    function new();
      min_lat = '0;
      errors = 0;
      checked = 0;
      clear_frames();
    endfunction

    function void clear_frames();
      head = 0;
      tail = 0;
      entries = 0;
      shown_valid = 0;
      shown_tag = '0;
      shown_src = '0;
      shown_rdy = '0;
      shown_elig = '0;
      shown_disp = '0;
      ticked = 0;
      last_tick = '0;
    endfunction

    function void set_min_latency(logic [MIN_LAT_W-1:0] v);
      min_lat = v;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Advance the queue model by one accepted word and queue its report
    function void apply_word(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] tag,
                             logic [TIME_W-1:0] src, logic [TIME_W-1:0] rdy,
                             logic [TIME_W-1:0] disp);
      status_t        st;
      pacing_report_t r;
      logic [32:0]    sum;
      logic [31:0]    elig;
      bit             popped;
      popped = 0;
      case (mode)
        MODE_PUSH: begin
          if (shown_valid && src <= shown_src) begin
            st = ST_STALE_DROP;
          end else if (entries >= QUEUE_DEPTH) begin
            st = ST_FULL_DROP;
          end else begin
            sum = {1'b0, src} + 33'(min_lat);
            elig = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (rdy > elig) elig = rdy;
            q_tag[tail] = tag;
            q_src[tail] = src;
            q_rdy[tail] = rdy;
            q_elig[tail] = elig;
            tail = (tail + 1) % QUEUE_DEPTH;
            entries++;
            st = ST_PUSHED;
          end
        end
        MODE_TICK: begin
          if (ticked && disp < last_tick) begin
            st = ST_BACKWARD;
          end else begin
            ticked = 1;
            last_tick = disp;
            // pop every head entry that is due by this tick
            while (entries > 0 && q_elig[head] <= disp) begin
              shown_tag = q_tag[head];
              shown_src = q_src[head];
              shown_rdy = q_rdy[head];
              shown_elig = q_elig[head];
              shown_valid = 1;
              popped = 1;
              head = (head + 1) % QUEUE_DEPTH;
              entries--;
            end
            if (shown_valid) shown_disp = disp;
            st = popped ? ST_NEW_FRAME : ST_NO_NEW;
          end
        end
        MODE_FLUSH: begin
          clear_frames();
          st = ST_FLUSHED;
        end
        default: st = ST_NO_NEW;
      endcase
      r = '0;
      r.status = st;
      r.has_frame = shown_valid;
      if (shown_valid) begin
        r.tag = shown_tag;
        r.source = shown_src;
        r.ready = shown_rdy;
        r.eligible = shown_elig;
        r.display = shown_disp;
        r.latency = shown_disp - shown_src;
      end
      r.queued = CNT_W'(entries);
      expected_reports = {expected_reports, r};
    endfunction

    task report(string what);
      errors++;
      $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("report %0d field %s got %0h want %0h", checked, name, got, want));
    endtask

    // Compare one accepted result word with the oldest pending report
    task check_report(logic [STATUS_W-1:0] st, logic [OUT_DATA_W-1:0] d);
      pacing_report_t w;
      if (expected_reports.size() == 0) begin
        report($sformatf("result word with no report pending, status %0d", st));
      end else begin
        w = expected_reports[0];
        expected_reports.delete(0);
        cmp_field("status", 32'(st), 32'(w.status));
        cmp_field("has_frame", 32'(d[0]), 32'(w.has_frame));
        cmp_field("shown_tag", 32'(d[O_TAG +: TAG_W]), 32'(w.tag));
        cmp_field("shown_source_us", d[O_SRC +: TIME_W], w.source);
        cmp_field("shown_ready_us", d[O_RDY +: TIME_W], w.ready);
        cmp_field("shown_eligible_us", d[O_ELIG +: TIME_W], w.eligible);
        cmp_field("shown_display_us", d[O_DISP +: TIME_W], w.display);
        cmp_field("latency_us", d[O_LAT +: TIME_W], w.latency);
        cmp_field("queued_count", 32'(d[O_CNT +: CNT_W]), 32'(w.queued));
        checked++;
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [MIN_LAT_W-1:0]  cfg_data = '0;

  frame_pacing_scoreboard sb = new();
  bit                     idle_on = 1'b1;
  int                     quiet_cycles = 0;
  logic [TIME_W-1:0]      cap_time;
  logic [TIME_W-1:0]      disp_time;
  logic [MIN_LAT_W-1:0]   cur_lat;

  frame_presentation_scheduler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stall the result side at random while idle_on is set
  always @(negedge clk) begin
    out_tready <= idle_on ? ($urandom_range(0, 99) >= 27) : 1'b1;
  end

  // Check result words and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_report(out_tuser, out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one word and hold it until accepted; starts and ends at a falling edge
  task automatic send_word(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] tag,
                           logic [TIME_W-1:0] src, logic [TIME_W-1:0] rdy,
                           logic [TIME_W-1:0] disp);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 27) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= IN_DATA_W'({disp, rdy, src, tag});
    do @(posedge clk); while (!in_tready);
    sb.apply_word(mode, tag, src, rdy, disp);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write the minimum latency once the block has gone quiet
  task automatic write_min_latency(logic [MIN_LAT_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_min_latency(v);
    cur_lat = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic restart_timeline();
    if ($urandom_range(0, 9) == 0) cap_time = 32'hFFF0_0000 + $urandom_range(0, 32'h000F_FFFF);
    else cap_time = $urandom_range(100000, 32'h7FFF_FFFF);
    disp_time = cap_time - 32'd50000;
  endtask

  // Mostly well-paced pushes and ticks, with some flushes, stale, backward and junk words
  task automatic send_random_word(int push_w);
    int                r;
    logic [TIME_W-1:0] cand;
    logic [TIME_W-1:0] src;
    r = $urandom_range(0, 99);
    if (r < push_w) begin
      cap_time = cap_time + $urandom_range(1, 40000);
      src = cap_time;
      send_word(MODE_PUSH, TAG_W'($urandom), src, src + $urandom_range(0, 30000), $urandom);
    end else if (r < 85) begin
      cand = cap_time - 32'd30000 + $urandom_range(0, int'(cur_lat) + 50000);
      if (cand >= disp_time) disp_time = cand;
      else disp_time = disp_time + $urandom_range(0, 100);
      send_word(MODE_TICK, TAG_W'($urandom), $urandom, $urandom, disp_time);
    end else if (r < 88) begin
      send_word(MODE_FLUSH, TAG_W'($urandom), $urandom, $urandom, $urandom);
      restart_timeline();
    end else if (r < 93) begin
      src = cap_time - $urandom_range(0, 200000);
      send_word(MODE_PUSH, TAG_W'($urandom), src, $urandom, $urandom);
    end else if (r < 96) begin
      send_word(MODE_TICK, TAG_W'($urandom), $urandom, $urandom,
                disp_time - $urandom_range(1, 1000));
    end else if (r < 98) begin
      send_word(MODE_SPARE, TAG_W'($urandom), $urandom, $urandom, $urandom);
    end else begin
      send_word(MODE_W'($urandom_range(0, 3)), TAG_W'($urandom), $urandom, $urandom,
                $urandom);
    end
  endtask

  initial begin
    int push_w;
    int pick;
    cur_lat = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty tick, spare mode, pacing by latency, stale, backward,
    // saturated eligible time, full queue, draining tick, flush
    write_min_latency(MIN_LAT_W'(LAT_MAX));
    send_word(MODE_TICK, '0, '0, '0, 32'd0);
    send_word(MODE_SPARE, '1, '1, '1, '1);
    send_word(MODE_PUSH, 16'hFFFF, 32'd1, 32'd0, '0);
    send_word(MODE_TICK, '0, '0, '0, 32'd10000000);
    send_word(MODE_TICK, '0, '0, '0, 32'd10000001);
    send_word(MODE_PUSH, 16'h1234, 32'd1, 32'd5, '0);
    send_word(MODE_TICK, '0, '0, '0, 32'd5);
    send_word(MODE_PUSH, 16'h0000, 32'hFFFF_FFFF, 32'h1234_5678, '0);
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      send_word(MODE_PUSH, TAG_W'(i * 4099), 32'h8000_0000 + i,
                (i % 2) ? 32'hFFFF_FFFF : 32'h0, '0);
    end
    send_word(MODE_PUSH, 16'h5A5A, 32'h9000_0000, 32'h0, '0);
    send_word(MODE_TICK, '0, '0, '0, 32'hFFFF_FFFF);
    send_word(MODE_FLUSH, '0, '0, '0, '0);

    // Random phases, each under its own latency setting
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        write_min_latency('0);
      end else if (ph == 1) begin
        write_min_latency(MIN_LAT_W'(LAT_MAX));
      end else begin
        pick = $urandom_range(0, 3);
        if (pick == 0) write_min_latency('0);
        else if (pick == 1) write_min_latency(MIN_LAT_W'($urandom_range(0, 20000)));
        else write_min_latency(MIN_LAT_W'($urandom_range(0, LAT_MAX)));
      end
      idle_on = !(ph == 3 || ph == 4);
      pick = $urandom_range(0, 2);
      push_w = (pick == 0) ? 30 : (pick == 1) ? 45 : 70;
      send_word(MODE_FLUSH, TAG_W'($urandom), $urandom, $urandom, $urandom);
      restart_timeline();
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 2 && n == PHASE_WORDS / 2) wait_drained();
        send_random_word(push_w);
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
